/* rtl/i2c_transaction_sequencer_assert.svh */
// assertion macros for the i2c transaction sequencer
// no dependencies; included by the modules that check their own logic
`ifndef I2C_TRANSACTION_SEQUENCER_ASSERT_SVH
`define I2C_TRANSACTION_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define I2CTS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define I2CTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define I2CTS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define I2CTS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/i2cts_pkg.sv */
// shared types and constants of the i2c transaction sequencer
// no dependencies
package i2cts_pkg;

  localparam int BUF_DEPTH = 32;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_START  = 2'd1,
    MODE_EVENT  = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_SEND    = 3'd2,
    ACT_STOP    = 3'd3,
    ACT_RELEASE = 3'd4,
    ACT_ACK     = 3'd5,
    ACT_NACK    = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    LS_IDLE  = 3'd0,
    LS_BUSY  = 3'd1,
    LS_WDONE = 3'd2,
    LS_ARB   = 3'd3,
    LS_FULL  = 3'd4,
    LS_NACK  = 3'd5
  } link_t;

  localparam logic [7:0] ST_BUS_ERR    = 8'h00;
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RESTART    = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK = 8'h20;
  localparam logic [7:0] ST_DW_ACK     = 8'h28;
  localparam logic [7:0] ST_DW_NACK    = 8'h30;
  localparam logic [7:0] ST_ARB_LOST   = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;
  localparam logic [7:0] ST_SLA_R_NACK = 8'h48;
  localparam logic [7:0] ST_DR_ACK     = 8'h50;
  localparam logic [7:0] ST_DR_NACK    = 8'h58;
  localparam logic [7:0] ST_SR_SLA     = 8'h60;
  localparam logic [7:0] ST_SR_ARB_SLA = 8'h68;
  localparam logic [7:0] ST_SR_GEN     = 8'h70;
  localparam logic [7:0] ST_SR_ARB_GEN = 8'h78;
  localparam logic [7:0] ST_SR_DATA    = 8'h80;
  localparam logic [7:0] ST_SR_DATA_N  = 8'h88;
  localparam logic [7:0] ST_SR_GDATA   = 8'h90;
  localparam logic [7:0] ST_SR_GDATA_N = 8'h98;
  localparam logic [7:0] ST_SR_STOP    = 8'hA0;
  localparam logic [7:0] ST_CODE_MASK  = 8'hF8;

  localparam logic [2:0] REG_STOP_AFTER_READ = 3'd0;

endpackage

/* rtl/i2c_transaction_sequencer.sv */
// i2c transaction sequencer: input register, decision logic, result register
// depends on i2cts_pkg and i2c_transaction_sequencer_assert.svh
// an accepted input beat is held in the input register; its result is registered in the result register
// throughput: one beat per cycle through the combinational decision path; the input
// stalls only when the input register is full and the result register is stalled
// reset clears valids, link state, address, position, length, stop_after_read; not the buffer
`include "i2c_transaction_sequencer_assert.svh"
module i2c_transaction_sequencer
  import i2cts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [4:0] buf_index,
  input  logic [7:0] write_byte,
  input  logic [6:0] target_addr,
  input  logic [5:0] length,
  input  logic       read_not_write,
  input  logic [7:0] bus_status,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] action,
  output logic [7:0] tx_byte,
  output logic [2:0] link_state,
  output logic [5:0] byte_count,
  output logic       start_refused,
  output logic       rx_valid,
  output logic [7:0] rx_data,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  logic       stop_after_read;

  logic       s_valid;
  mode_t      s_mode;
  logic [4:0] s_index;
  logic [7:0] s_wbyte;
  logic [6:0] s_addr;
  logic [5:0] s_len;
  logic       s_rnw;
  logic [7:0] s_status;
  logic [7:0] s_rxb;

  link_t      link_status, link_next;
  logic [7:0] address_with_rw, address_next;
  logic [5:0] byte_position, position_next;
  logic [5:0] message_length, length_next;
  logic [7:0] tx_buffer [BUF_DEPTH];

  action_t    res_action;
  logic [7:0] res_tx;
  logic       res_refused;
  logic       res_rxv;
  logic [7:0] res_rxd;

  logic       accept;
  logic       advance;
  logic [7:0] code;
  logic [5:0] pos_bumped;
  logic [6:0] pos_plus_one;
  logic       pos_in_buf;
  logic [7:0] buf_rd;

  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_STOP_AFTER_READ[2]) ? {31'd0, stop_after_read} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_after_read <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_STOP_AFTER_READ[2]) begin
      stop_after_read <= pwdata[0];
    end
  end

  assign advance  = s_valid && (!out_valid || !out_stall);
  assign in_stall = s_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_mode   <= mode_t'(mode);
      s_index  <= buf_index;
      s_wbyte  <= write_byte;
      s_addr   <= target_addr;
      s_len    <= length;
      s_rnw    <= read_not_write;
      s_status <= bus_status;
      s_rxb    <= rx_byte;
    end
  end

  assign code         = s_status & ST_CODE_MASK;
  assign pos_bumped   = (byte_position == 6'h3F) ? byte_position : byte_position + 6'd1;
  assign pos_plus_one = {1'b0, pos_bumped} + 7'd1;
  assign pos_in_buf   = int'(byte_position) < BUF_DEPTH;
  assign buf_rd       = tx_buffer[byte_position[BUF_AW-1:0]];

  always_comb begin
    link_next     = link_status;
    address_next  = address_with_rw;
    position_next = byte_position;
    length_next   = message_length;
    res_action    = ACT_NONE;
    res_tx        = 8'd0;
    res_refused   = 1'b0;
    res_rxv       = 1'b0;
    res_rxd       = 8'd0;
    case (s_mode)
      MODE_LOAD: begin
      end
      MODE_START: begin
        if (link_status == LS_BUSY) begin
          res_refused = 1'b1;
        end else begin
          link_next     = LS_BUSY;
          address_next  = {s_addr, s_rnw};
          position_next = 6'd0;
          length_next   = s_len;
          res_action    = ACT_START;
        end
      end
      MODE_CLEAR: begin
        link_next = LS_IDLE;
      end
      MODE_EVENT: begin
        case (code)
          ST_START, ST_RESTART: begin
            res_action = ACT_SEND;
            res_tx     = address_with_rw;
          end
          ST_SLA_W_ACK, ST_DW_ACK: begin
            if (byte_position < message_length && pos_in_buf) begin
              res_action    = ACT_SEND;
              res_tx        = buf_rd;
              position_next = pos_bumped;
            end else begin
              res_action = ACT_STOP;
              link_next  = LS_WDONE;
            end
          end
          ST_ARB_LOST: begin
            res_action = ACT_RELEASE;
            link_next  = LS_ARB;
          end
          ST_DR_ACK: begin
            res_rxv       = 1'b1;
            res_rxd       = s_rxb;
            position_next = pos_bumped;
            res_action    = (pos_plus_one < {1'b0, message_length}) ? ACT_ACK : ACT_NACK;
          end
          ST_SLA_R_ACK: begin
            res_action = ({1'b0, byte_position} + 7'd1 < {1'b0, message_length}) ?
                         ACT_ACK : ACT_NACK;
          end
          ST_DR_NACK: begin
            res_rxv       = 1'b1;
            res_rxd       = s_rxb;
            position_next = pos_bumped;
            link_next     = LS_FULL;
            if (stop_after_read) begin
              res_action = ACT_STOP;
            end
          end
          ST_SLA_W_NACK, ST_SLA_R_NACK, ST_DW_NACK: begin
            link_next  = LS_NACK;
            res_action = ACT_STOP;
          end
          ST_SR_SLA, ST_SR_ARB_SLA, ST_SR_GEN, ST_SR_ARB_GEN: begin
            link_next  = LS_BUSY;
            res_action = ACT_ACK;
          end
          ST_SR_DATA, ST_SR_GDATA: begin
            res_action = ACT_ACK;
          end
          ST_SR_DATA_N, ST_SR_GDATA_N: begin
            res_action = ACT_RELEASE;
          end
          ST_SR_STOP: begin
            link_next  = LS_IDLE;
            res_action = ACT_RELEASE;
          end
          ST_BUS_ERR: begin
            res_action = ACT_STOP;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_status     <= LS_IDLE;
      address_with_rw <= 8'd0;
      byte_position   <= 6'd0;
      message_length  <= 6'd0;
    end else if (advance) begin
      link_status     <= link_next;
      address_with_rw <= address_next;
      byte_position   <= position_next;
      message_length  <= length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s_mode == MODE_LOAD && int'(s_index) < BUF_DEPTH) begin
      tx_buffer[s_index[BUF_AW-1:0]] <= s_wbyte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      action        <= res_action;
      tx_byte       <= res_tx;
      link_state    <= link_next;
      byte_count    <= position_next;
      start_refused <= res_refused;
      rx_valid      <= res_rxv;
      rx_data       <= res_rxd;
    end
  end

  `I2CTS_ASSERT_IMPLY(a_stall_only_when_full, clk, rst, in_stall, s_valid && out_valid && out_stall)
  `I2CTS_ASSERT_IMPLY(a_refused_stays_busy, clk, rst, out_valid && start_refused, link_state == LS_BUSY)
  `I2CTS_ASSERT_IMPLY(a_start_clears_count, clk, rst, out_valid && action == ACT_START, byte_count == 6'd0 && link_state == LS_BUSY)
  `I2CTS_ASSERT_IMPLY(a_tx_only_on_send, clk, rst, out_valid && tx_byte != 8'd0, action == ACT_SEND)
  `I2CTS_ASSERT_NEXT(a_advance_fills_output, clk, rst, advance, out_valid)

endmodule
